@@ design/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Types and codes shared by the SOR pressure solver core.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int OP_W      = 2;
   localparam int COORD_W   = 6;
   localparam int TYPE_W    = 2;
   localparam int DATA_W    = 32;
   localparam int LIMIT_W   = 12;
   localparam int RELAX_W   = 17;
   localparam int TOL_W     = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   localparam logic [TYPE_W-1:0] CELL_WALL   = 2'd1;
   localparam logic [TYPE_W-1:0] CELL_OUTLET = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RELAX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL   = 1'b1;

   localparam logic [RELAX_W-1:0] RELAX_RESET = 17'd125952;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 16'd308;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [COORD_W-1:0]        cell_x;
      logic [COORD_W-1:0]        cell_y;
      logic [TYPE_W-1:0]         cell_type;
      logic signed [DATA_W-1:0]  source;
      logic [LIMIT_W-1:0]        iteration_limit;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  pressure;
      logic [LIMIT_W-1:0]        sweeps_done;
      logic                      converged;
   } rsp_type;

endpackage

@@ design/sor_pressure_solver_core.sv @@
// ----------------------------------------------------------------------------
// sor_pressure_solver_core
// Fixed-point SOR pressure solver over a grid held in block RAM.
// ----------------------------------------------------------------------------
// Read beat: registered pressure RAM read.
// Solve beat: each sweep updates the (GRID_X-2)*(GRID_Y-2) interior cells,
//   then may run a snapshot or check pass over (GRID_X/2)*(GRID_Y/2) cells;
//   updates share one multiplier and the single pressure RAM read port.
// Reset: synchronous; then a clearing pass over all GRID_X*GRID_Y cells
//   zeroes the pressure RAM while req_stall stays high.
// ----------------------------------------------------------------------------
module sor_pressure_solver_core #(
   parameter int GRID_X       = 64,
   parameter int GRID_Y       = 34,
   parameter int CHECK_PERIOD = 5,
   parameter int FRAC_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  sps_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output sps_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [sps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sps_pkg::RELAX_W-1:0]        csr_wdata
);
   import sps_pkg::*;

   localparam int CELLS = GRID_X * GRID_Y;
   localparam int AW    = $clog2(CELLS);
   localparam int SX    = GRID_X / 2;
   localparam int SY    = GRID_Y / 2;
   localparam int SNAPS = SX * SY;
   localparam int SNW   = $clog2(SNAPS);
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int SXW   = $clog2(SX);
   localparam int SYW   = $clog2(SY);
   localparam int PHW   = $clog2(CHECK_PERIOD);
   localparam int SH    = FRAC_BITS + 2;
   localparam int KW    = ((FRAC_BITS + 3 > 20) ? FRAC_BITS + 3 : 20) + 1;
   localparam int MA_W  = 36;
   localparam int PW    = MA_W + KW;
   localparam int ACW   = PW + 1;
   localparam int SUM_W = DATA_W + 2;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_UPD   = 5'b01000,
      ST_SNAP  = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_ff, clr_in;
   logic [RELAX_W-1:0]       relax_ff, relax_in;
   logic [TOL_W-1:0]         tol_ff, tol_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic [LIMIT_W-1:0]       sweep_ff, sweep_in;
   logic [PHW-1:0]           phase_ff, phase_in;
   logic                     take_ff, take_in;
   logic                     ok_ff, ok_in;
   logic [XW-1:0]            x_ff, x_in;
   logic [YW-1:0]            y_ff, y_in;
   logic [AW-1:0]            c_ff, c_in;
   logic [2:0]               step_ff, step_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [2:0]               walls_ff, walls_in;
   logic                     outlet_ff, outlet_in;
   logic signed [MA_W-1:0]   diff_ff, diff_in;
   logic signed [PW-1:0]     prod_ff, prod_in;
   logic signed [PW-1:0]     prod2_ff, prod2_in;
   logic [SXW-1:0]           si_ff, si_in;
   logic [SYW-1:0]           sj_ff, sj_in;
   logic [AW-1:0]            pa_ff, pa_in;
   logic [SNW-1:0]           sn_ff, sn_in;

   logic                     req_take;
   logic                     in_grid;
   logic [AW-1:0]            req_addr;
   logic                     p_we;
   logic [AW-1:0]            p_waddr, p_raddr;
   logic [DATA_W-1:0]        p_wdata, p_q;
   logic signed [DATA_W-1:0] p_q_s;
   logic [TYPE_W-1:0]        type_q;
   logic [DATA_W-1:0]        src_q;
   logic [DATA_W-1:0]        snap_q;
   logic                     snap_we;
   logic                     cell_we;
   logic [AW-1:0]            upd_addr;
   logic signed [KW-1:0]     k_coef;
   logic [KW-1:0]            nw_w;
   logic [2:0]               n_open;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [KW-1:0]     mul_b;
   logic signed [PW-1:0]     mul_p;
   logic signed [ACW-1:0]    acc, rnd;
   logic signed [DATA_W-1:0] upd_val;
   logic signed [DATA_W:0]   snap_d;
   logic [DATA_W:0]          snap_abs;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign in_grid   = (int'(req_data.cell_x) < GRID_X) && (int'(req_data.cell_y) < GRID_Y);
   assign req_addr  = AW'(int'(req_data.cell_x) * GRID_Y + int'(req_data.cell_y));
   assign cell_we   = req_take && (req_data.operation == OP_WRITE) && in_grid;
   assign p_q_s     = signed'(p_q);

   always_comb begin
      unique case (step_ff)
         3'd0:    upd_addr = c_ff - AW'(1);
         3'd1:    upd_addr = c_ff - AW'(GRID_Y);
         3'd2:    upd_addr = c_ff + AW'(GRID_Y);
         3'd3:    upd_addr = c_ff + AW'(1);
         default: upd_addr = c_ff;
      endcase
   end

   assign n_open = 3'd4 - walls_ff;
   always_comb begin
      unique case (n_open)
         3'd0:    nw_w = '0;
         3'd1:    nw_w = KW'(relax_ff);
         3'd2:    nw_w = KW'(relax_ff) << 1;
         3'd3:    nw_w = KW'(relax_ff) + (KW'(relax_ff) << 1);
         default: nw_w = KW'(relax_ff) << 2;
      endcase
   end
   assign k_coef = (KW'(1) << SH) - signed'(nw_w);

   assign mul_a = (step_ff == 3'd5) ? MA_W'(p_q_s) : diff_ff;
   assign mul_b = (step_ff == 3'd5) ? k_coef : signed'(KW'(relax_ff));
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   assign acc = ACW'(prod_ff) + ACW'(prod2_ff);
   assign rnd = (acc + (signed'(ACW'(1)) <<< (SH - 1))) >>> SH;
   always_comb begin
      if ((&rnd[ACW-1:DATA_W-1]) || !(|rnd[ACW-1:DATA_W-1])) begin
         upd_val = rnd[DATA_W-1:0];
      end else if (rnd[ACW-1]) begin
         upd_val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         upd_val = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign snap_d   = (DATA_W+1)'(p_q_s) - (DATA_W+1)'(signed'(snap_q));
   assign snap_abs = snap_d[DATA_W] ? unsigned'(-snap_d) : unsigned'(snap_d);

   always_comb begin
      p_we    = 1'b0;
      p_waddr = c_ff;
      p_wdata = '0;
      p_raddr = '0;
      snap_we = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            p_we    = 1'b1;
            p_waddr = clr_ff;
         end
         ST_IDLE:  p_raddr = req_addr;
         ST_UPD: begin
            p_raddr = upd_addr;
            if (step_ff == 3'd7) begin
               p_we    = 1'b1;
               p_wdata = outlet_ff ? '0 : upd_val;
            end
         end
         ST_SNAP: begin
            p_raddr = pa_ff;
            snap_we = (step_ff == 3'd1) && take_ff;
         end
         default: p_raddr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      relax_in     = relax_ff;
      tol_in       = tol_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      rd_ok_in     = rd_ok_ff;
      limit_in     = limit_ff;
      sweep_in     = sweep_ff;
      phase_in     = phase_ff;
      take_in      = take_ff;
      ok_in        = ok_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      c_in         = c_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      walls_in     = walls_ff;
      outlet_in    = outlet_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      prod2_in     = prod2_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      pa_in        = pa_ff;
      sn_in        = sn_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_RELAX: relax_in = csr_wdata;
            CSR_TOL:   tol_in   = csr_wdata[TOL_W-1:0];
            default:   relax_in = relax_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               rsp_in = '0;
               unique case (req_data.operation)
                  OP_READ: begin
                     rd_ok_in = in_grid;
                     state_in = ST_READ;
                  end
                  OP_SOLVE: begin
                     limit_in = req_data.iteration_limit;
                     sweep_in = '0;
                     phase_in = '0;
                     x_in     = XW'(1);
                     y_in     = YW'(1);
                     c_in     = AW'(GRID_Y + 1);
                     step_in  = '0;
                     if (req_data.iteration_limit == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_UPD;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_in.pressure = rd_ok_ff ? p_q_s : '0;
            rsp_valid_in    = 1'b1;
            state_in        = ST_IDLE;
         end
         ST_UPD: begin
            step_in = step_ff + 3'd1;
            unique case (step_ff)
               3'd0: begin
                  sum_in   = '0;
                  walls_in = '0;
               end
               3'd1, 3'd2, 3'd3, 3'd4: begin
                  if (type_q == CELL_WALL) begin
                     walls_in = walls_ff + 3'd1;
                  end else begin
                     sum_in = sum_ff + SUM_W'(p_q_s);
                  end
               end
               3'd5: begin
                  outlet_in = (type_q == CELL_OUTLET);
                  diff_in   = MA_W'(sum_ff) - MA_W'(signed'(src_q));
                  prod_in   = mul_p;
               end
               3'd6: prod2_in = mul_p;
               default: begin
                  step_in = '0;
                  if (y_ff == YW'(GRID_Y - 2)) begin
                     y_in = YW'(1);
                     x_in = x_ff + XW'(1);
                     c_in = c_ff + AW'(3);
                  end else begin
                     y_in = y_ff + YW'(1);
                     c_in = c_ff + AW'(1);
                  end
                  if ((y_ff == YW'(GRID_Y - 2)) && (x_ff == XW'(GRID_X - 2))) begin
                     sweep_in = sweep_ff + LIMIT_W'(1);
                     phase_in = (phase_ff == PHW'(CHECK_PERIOD - 1)) ? '0
                                                                      : phase_ff + PHW'(1);
                     x_in     = XW'(1);
                     y_in     = YW'(1);
                     c_in     = AW'(GRID_Y + 1);
                     si_in    = '0;
                     sj_in    = '0;
                     pa_in    = '0;
                     sn_in    = '0;
                     ok_in    = 1'b1;
                     if (phase_ff == PHW'(CHECK_PERIOD - 2)) begin
                        take_in  = 1'b1;
                        state_in = ST_SNAP;
                     end else if (phase_ff == PHW'(CHECK_PERIOD - 1)) begin
                        take_in  = 1'b0;
                        state_in = ST_SNAP;
                     end else if (sweep_ff + LIMIT_W'(1) == limit_ff) begin
                        rsp_in.sweeps_done = limit_ff;
                        rsp_in.converged   = 1'b0;
                        rsp_valid_in       = 1'b1;
                        state_in           = ST_IDLE;
                     end
                  end
               end
            endcase
         end
         ST_SNAP: begin
            if (step_ff == 3'd0) begin
               step_in = 3'd1;
            end else begin
               step_in = 3'd0;
               if (!take_ff && (snap_abs > (DATA_W+1)'(tol_ff))) begin
                  ok_in = 1'b0;
               end
               sn_in = sn_ff + SNW'(1);
               if (sj_ff == SYW'(SY - 1)) begin
                  sj_in = '0;
                  si_in = si_ff + SXW'(1);
                  pa_in = pa_ff + AW'(2 * GRID_Y - 2 * (SY - 1));
                  if (si_ff == SXW'(SX - 1)) begin
                     if (!take_ff && ok_in) begin
                        rsp_in.sweeps_done = sweep_ff;
                        rsp_in.converged   = 1'b1;
                        rsp_valid_in       = 1'b1;
                        state_in           = ST_IDLE;
                     end else if (sweep_ff == limit_ff) begin
                        rsp_in.sweeps_done = sweep_ff;
                        rsp_in.converged   = 1'b0;
                        rsp_valid_in       = 1'b1;
                        state_in           = ST_IDLE;
                     end else begin
                        state_in = ST_UPD;
                     end
                  end
               end else begin
                  sj_in = sj_ff + SYW'(1);
                  pa_in = pa_ff + AW'(2);
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         relax_ff     <= RELAX_RESET;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         relax_ff     <= relax_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      rsp_ff    <= rsp_in;
      rd_ok_ff  <= rd_ok_in;
      limit_ff  <= limit_in;
      sweep_ff  <= sweep_in;
      phase_ff  <= phase_in;
      take_ff   <= take_in;
      ok_ff     <= ok_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      c_ff      <= c_in;
      sum_ff    <= sum_in;
      walls_ff  <= walls_in;
      outlet_ff <= outlet_in;
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      prod2_ff  <= prod2_in;
      si_ff     <= si_in;
      sj_ff     <= sj_in;
      pa_ff     <= pa_in;
      sn_ff     <= sn_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   sps_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_pressure_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_q)
   );

   sps_ram #(.WIDTH(TYPE_W), .DEPTH(CELLS)) u_type_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (req_addr),
      .wr_data (req_data.cell_type),
      .rd_addr (p_raddr),
      .rd_data (type_q)
   );

   sps_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_source_ram (
      .clock   (clock),
      .wr_en   (cell_we),
      .wr_addr (req_addr),
      .wr_data (req_data.source),
      .rd_addr (c_ff),
      .rd_data (src_q)
   );

   sps_ram #(.WIDTH(DATA_W), .DEPTH(SNAPS)) u_snapshot_ram (
      .clock   (clock),
      .wr_en   (snap_we),
      .wr_addr (sn_ff),
      .wr_data (p_q),
      .rd_addr (sn_ff),
      .rd_data (snap_q)
   );

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (state_ff == ST_IDLE))
      else $error("beat taken while busy");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (sweep_ff < limit_ff))
      else $error("sweep count past limit");

   a_clear_stall: assert property (@(posedge clock)
      (state_ff == ST_CLEAR) |-> (req_stall && !rsp_valid))
      else $error("request taken during clearing pass");

endmodule

@@ design/sps_ram.sv @@
// ----------------------------------------------------------------------------
// sps_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
